// ----- hw/rtl/weighted_sorted_priority_queue_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the weighted sorted priority queue
// Shorthand for clocked implication checks, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define WEIGHTED_SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication.
`define WSPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wspq assertion failed");

// Next-cycle implication.
`define WSPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wspq assertion failed");

`endif

// ----- hw/rtl/wspq_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted sorted priority queue package
// Sizes, codes and word types shared by the queue modules.
// ----------------------------------------------------------------------------
package wspq_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int DEPTH    = 2 ** AW;

    localparam int GRADE_W   = 14;
    localparam int COURSES_W = 6;
    localparam int PAYLOAD_W = 16;
    localparam int KEY_W     = 21;
    localparam int PROD_W    = GRADE_W + COURSES_W;
    localparam int CFG_W     = 14;

    localparam logic FN_ENQ = 1'b0;
    localparam logic FN_DEQ = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic REG_MAX_GRADE = 1'b0;
    localparam logic REG_TOTAL     = 1'b1;

    localparam logic [GRADE_W-1:0]   MAX_GRADE_RST = 14'd1000;
    localparam logic [COURSES_W-1:0] TOTAL_RST     = 6'd30;

    typedef struct packed {
        logic                 func;
        logic [PAYLOAD_W-1:0] payload;
        logic [GRADE_W-1:0]   grade;
        logic [COURSES_W-1:0] courses;
    } t_in_word;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] front_payload;
        logic [GRADE_W-1:0]   front_grade;
        logic [COURSES_W-1:0] front_courses;
        logic [KEY_W-1:0]     front_key;
        logic [6:0]           count;
        logic                 is_empty;
        logic [1:0]           status;
    } t_out_word;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [GRADE_W-1:0]   grade;
        logic [COURSES_W-1:0] courses;
        logic [KEY_W-1:0]     key;
    } t_entry;

    typedef struct packed {
        logic en;
        logic clr;
    } t_mac_ctl;

endpackage

// ----- hw/rtl/wspq_mac.sv -----
// ----------------------------------------------------------------------------
// Key multiply-accumulate unit
// Shared 14x6 multiplier with a 21-bit accumulator, used for both key terms.
// ----------------------------------------------------------------------------
module wspq_mac
    import wspq_pkg::*;
(
    input  logic                 i_clk,
    input  t_mac_ctl             i_ctl,
    input  logic [GRADE_W-1:0]   i_a,
    input  logic [COURSES_W-1:0] i_b,
    output logic [KEY_W-1:0]     o_acc
);

    logic [PROD_W-1:0] w_prod;
    logic [KEY_W-1:0]  r_acc;
    logic [KEY_W-1:0]  n_acc;

    assign w_prod = i_a * i_b;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.en) begin
            if (i_ctl.clr) begin
                n_acc = KEY_W'(w_prod);
            end else begin
                n_acc = r_acc + KEY_W'(w_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ----- hw/rtl/weighted_sorted_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// Weighted sorted priority queue
// Ring-buffer queue kept in descending key order; inserts shift entries one
// at a time under a small sequencer with a shared key multiplier.
//
// Channel   Direction  Handshake                    Word
// in        input      i_in_valid / o_in_stall      i_in_word  (t_in_word)
// out       output     o_out_valid / i_out_stall    o_out_word (t_out_word)
// cfg       input      i_cfg_we                     i_cfg_idx, i_cfg_data
//
// A dequeue or rejected word passes S_FREAD (front read) and S_FWAIT (result
// load). An enqueue forms its key in S_MUL1 and S_MUL2, runs S_SCAN and
// S_CMP per entry moved back, with no final S_CMP when it lands at the front,
// then S_FREAD and S_FWAIT. The single-port entry memory is read then
// written once per moved entry. The next word can be taken after the load.
// The queue is empty after reset; the entry memory needs no clearing pass.
// The block takes one word at a time; a stalled result holds its word and
// the next word waits for its slot.
// ----------------------------------------------------------------------------
module weighted_sorted_priority_queue_top
    import wspq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    `include "weighted_sorted_priority_queue_top_assert.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL1  = 3'd1;
    localparam logic [2:0] S_MUL2  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_FREAD = 3'd5;
    localparam logic [2:0] S_FWAIT = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_idx, n_idx;
    logic [1:0]           r_status, n_status;
    logic [PAYLOAD_W-1:0] r_payload;
    logic [GRADE_W-1:0]   r_grade;
    logic [COURSES_W-1:0] r_courses;
    logic [GRADE_W-1:0]   r_cfg_max;
    logic [COURSES_W-1:0] r_cfg_total;
    logic                 r_out_valid;
    t_out_word            r_out;

    t_entry               mem [DEPTH];
    t_entry               r_rd;
    logic                 w_we, w_re;
    logic [AW-1:0]        w_waddr, w_raddr;
    t_entry               w_wdata;
    t_entry               w_new;

    logic                 w_in_acc;
    logic                 w_out_load;
    logic                 w_full;
    logic [GRADE_W-1:0]   w_sat_grade;
    logic [COURSES_W-1:0] w_sat_courses;
    logic [AW-1:0]        w_addr_cur, w_addr_prev;

    t_mac_ctl             w_mac_ctl;
    logic [GRADE_W-1:0]   w_mac_a;
    logic [COURSES_W-1:0] w_mac_b;
    logic [KEY_W-1:0]     w_key;

    wspq_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_mac_ctl),
        .i_a   (w_mac_a),
        .i_b   (w_mac_b),
        .o_acc (w_key)
    );

    assign o_in_stall    = (r_state != S_IDLE);
    assign w_in_acc      = i_in_valid && (r_state == S_IDLE);
    assign w_full        = (r_count >= CW'(CAPACITY));
    assign w_sat_grade   = (i_in_word.grade > r_cfg_max) ? r_cfg_max : i_in_word.grade;
    assign w_sat_courses = (i_in_word.courses > r_cfg_total) ? r_cfg_total
                                                             : i_in_word.courses;
    assign w_addr_cur    = r_head + r_idx;
    assign w_addr_prev   = r_head + r_idx - AW'(1);
    assign w_out_load    = (r_state == S_FWAIT) && (!r_out_valid || !i_out_stall);

    assign w_new.payload = r_payload;
    assign w_new.grade   = r_grade;
    assign w_new.courses = r_courses;
    assign w_new.key     = w_key;

    always_comb begin
        w_mac_ctl.en  = (r_state == S_MUL1) || (r_state == S_MUL2);
        w_mac_ctl.clr = (r_state == S_MUL1);
        if (r_state == S_MUL1) begin
            w_mac_a = r_grade;
            w_mac_b = r_cfg_total;
        end else begin
            w_mac_a = r_cfg_max;
            w_mac_b = r_courses;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_head   = r_head;
        n_idx    = r_idx;
        n_status = r_status;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_waddr  = w_addr_cur;
        w_raddr  = r_head;
        w_wdata  = w_new;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_status = ST_DONE;
                    if (i_in_word.func == FN_ENQ) begin
                        if (w_full) begin
                            n_status = ST_FULL;
                            n_state  = S_FREAD;
                        end else begin
                            n_state = S_MUL1;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_head  = r_head + AW'(1);
                            n_count = r_count - CW'(1);
                        end
                        n_state = S_FREAD;
                    end
                end
            end
            S_MUL1: begin
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_idx   = AW'(r_count);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_idx == '0) begin
                    w_we    = 1'b1;
                    n_count = r_count + CW'(1);
                    n_state = S_FREAD;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_addr_prev;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_we = 1'b1;
                if (r_rd.key >= w_key) begin
                    n_count = r_count + CW'(1);
                    n_state = S_FREAD;
                end else begin
                    w_wdata = r_rd;
                    n_idx   = r_idx - AW'(1);
                    n_state = S_SCAN;
                end
            end
            S_FREAD: begin
                w_re    = 1'b1;
                n_state = S_FWAIT;
            end
            S_FWAIT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_idx       <= '0;
            r_status    <= ST_DONE;
            r_out_valid <= 1'b0;
            r_cfg_max   <= MAX_GRADE_RST;
            r_cfg_total <= TOTAL_RST;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_head   <= n_head;
            r_idx    <= n_idx;
            r_status <= n_status;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MAX_GRADE: r_cfg_max   <= i_cfg_data;
                    REG_TOTAL:     r_cfg_total <= i_cfg_data[COURSES_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_payload <= i_in_word.payload;
            r_grade   <= w_sat_grade;
            r_courses <= w_sat_courses;
        end
        if (w_out_load) begin
            if (r_count == '0) begin
                r_out.front_payload <= '0;
                r_out.front_grade   <= '0;
                r_out.front_courses <= '0;
                r_out.front_key     <= '0;
                r_out.is_empty      <= 1'b1;
            end else begin
                r_out.front_payload <= r_rd.payload;
                r_out.front_grade   <= r_rd.grade;
                r_out.front_courses <= r_rd.courses;
                r_out.front_key     <= r_rd.key;
                r_out.is_empty      <= 1'b0;
            end
            r_out.count  <= 7'(r_count);
            r_out.status <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `WSPQ_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `WSPQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, r_state != S_IDLE)
    `WSPQ_ASSERT_IMPL(a_write_in_insert, i_clk, i_rst_n, w_we,
                      (r_state == S_SCAN) || (r_state == S_CMP))
    `WSPQ_ASSERT_IMPL(a_empty_count, i_clk, i_rst_n, r_out_valid && r_out.is_empty,
                      r_out.count == 7'd0)

endmodule
